// ===== rtl/core/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types, constants and step numbers for the telemetry frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] DEST_RESET  = 8'hFF;
    localparam logic [7:0] ID_RESET    = 8'hF1;
    localparam logic [7:0] LEN_RAW     = 8'd12;
    localparam logic [7:0] LEN_ANGLE   = 8'd6;
    localparam logic signed [7:0] ANGLE_SCALE = 8'sd100;
    localparam int ANGLE_FRAC_BITS = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID   = 2'd1;

    // Program counter and step numbers
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_ACCEPT  = 5'd0;
    localparam step_t STEP_MODE    = 5'd1;
    localparam step_t STEP_MUL0    = 5'd2;
    localparam step_t STEP_MUL1    = 5'd3;
    localparam step_t STEP_MUL2    = 5'd4;
    localparam step_t STEP_STORE2  = 5'd5;
    localparam step_t STEP_SYNC    = 5'd6;
    localparam step_t STEP_DEST    = 5'd7;
    localparam step_t STEP_ID      = 5'd8;
    localparam step_t STEP_LEN     = 5'd9;
    localparam step_t STEP_WORD0   = 5'd10;
    localparam step_t STEP_WORD_A  = 5'd15;  // last payload byte of an angle frame
    localparam step_t STEP_WORD_R  = 5'd21;  // last payload byte of a raw frame
    localparam step_t STEP_SUM     = 5'd22;
    localparam step_t STEP_ACC     = 5'd23;

    // Byte source of an emit step
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_SYNC,
        SRC_DEST,
        SRC_ID,
        SRC_LEN,
        SRC_WORD,
        SRC_SUM,
        SRC_ACC
    } src_t;

    // Jump condition
    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_IF_RAW,
        JMP_IF_ANGLE
    } jmp_t;

    // One control word of the program
    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       store_en;
        logic [1:0] store_idx;
        src_t       src;
        logic [3:0] byte_idx;
        logic       ck_en;
        logic       last;
        jmp_t       jmp;
        step_t      target;
    } ctl_t;

    // Datapath and handshake status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic angle_mode;
    } status_t;

endpackage

// ===== rtl/core/tfb_urom.sv =====
// ----------------------------------------------------------------------------
// tfb_urom
// Microcode ROM: one control word per program step.
// ----------------------------------------------------------------------------
module tfb_urom
(
    input  tfb_pkg::step_t step,
    output tfb_pkg::ctl_t  ctl
);

    // Build a control word with every field given
    function automatic tfb_pkg::ctl_t mk(
        input logic           accept,
        input logic           mul_en,
        input logic [1:0]     mul_idx,
        input logic           store_en,
        input logic [1:0]     store_idx,
        input tfb_pkg::src_t  src,
        input logic [3:0]     byte_idx,
        input logic           ck_en,
        input logic           last,
        input tfb_pkg::jmp_t  jmp,
        input tfb_pkg::step_t target
    );
        tfb_pkg::ctl_t w;
        w.accept    = accept;
        w.mul_en    = mul_en;
        w.mul_idx   = mul_idx;
        w.store_en  = store_en;
        w.store_idx = store_idx;
        w.src       = src;
        w.byte_idx  = byte_idx;
        w.ck_en     = ck_en;
        w.last      = last;
        w.jmp       = jmp;
        w.target    = target;
        return w;
    endfunction

    // Emit one checksummed byte, no jump
    function automatic tfb_pkg::ctl_t emit(input tfb_pkg::src_t src, input logic [3:0] bidx);
        return mk(1'b0, 1'b0, 2'd0, 1'b0, 2'd0, src, bidx, 1'b1, 1'b0,
                  tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
    endfunction

    // Program
    always_comb
    begin
        unique case (step)
            tfb_pkg::STEP_ACCEPT:
                ctl = mk(1'b1, 1'b0, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
            tfb_pkg::STEP_MODE:
                ctl = mk(1'b0, 1'b0, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_IF_RAW, tfb_pkg::STEP_SYNC);
            tfb_pkg::STEP_MUL0:
                ctl = mk(1'b0, 1'b1, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
            tfb_pkg::STEP_MUL1:
                ctl = mk(1'b0, 1'b1, 2'd1, 1'b1, 2'd0, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
            tfb_pkg::STEP_MUL2:
                ctl = mk(1'b0, 1'b1, 2'd2, 1'b1, 2'd1, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
            tfb_pkg::STEP_STORE2:
                ctl = mk(1'b0, 1'b0, 2'd0, 1'b1, 2'd2, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
            tfb_pkg::STEP_SYNC:  ctl = emit(tfb_pkg::SRC_SYNC, 4'd0);
            tfb_pkg::STEP_DEST:  ctl = emit(tfb_pkg::SRC_DEST, 4'd0);
            tfb_pkg::STEP_ID:    ctl = emit(tfb_pkg::SRC_ID, 4'd0);
            tfb_pkg::STEP_LEN:   ctl = emit(tfb_pkg::SRC_LEN, 4'd0);
            5'd10:               ctl = emit(tfb_pkg::SRC_WORD, 4'd0);
            5'd11:               ctl = emit(tfb_pkg::SRC_WORD, 4'd1);
            5'd12:               ctl = emit(tfb_pkg::SRC_WORD, 4'd2);
            5'd13:               ctl = emit(tfb_pkg::SRC_WORD, 4'd3);
            5'd14:               ctl = emit(tfb_pkg::SRC_WORD, 4'd4);
            // angle frame ends its payload here
            tfb_pkg::STEP_WORD_A:
                ctl = mk(1'b0, 1'b0, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_WORD, 4'd5, 1'b1, 1'b0,
                         tfb_pkg::JMP_IF_ANGLE, tfb_pkg::STEP_SUM);
            5'd16:               ctl = emit(tfb_pkg::SRC_WORD, 4'd6);
            5'd17:               ctl = emit(tfb_pkg::SRC_WORD, 4'd7);
            5'd18:               ctl = emit(tfb_pkg::SRC_WORD, 4'd8);
            5'd19:               ctl = emit(tfb_pkg::SRC_WORD, 4'd9);
            5'd20:               ctl = emit(tfb_pkg::SRC_WORD, 4'd10);
            tfb_pkg::STEP_WORD_R: ctl = emit(tfb_pkg::SRC_WORD, 4'd11);
            tfb_pkg::STEP_SUM:
                ctl = mk(1'b0, 1'b0, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_SUM, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_NONE, tfb_pkg::STEP_ACCEPT);
            tfb_pkg::STEP_ACC:
                ctl = mk(1'b0, 1'b0, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_ACC, 4'd0, 1'b0, 1'b1,
                         tfb_pkg::JMP_ALWAYS, tfb_pkg::STEP_ACCEPT);
            // unused steps go back to the start
            default:
                ctl = mk(1'b0, 1'b0, 2'd0, 1'b0, 2'd0, tfb_pkg::SRC_NONE, 4'd0, 1'b0, 1'b0,
                         tfb_pkg::JMP_ALWAYS, tfb_pkg::STEP_ACCEPT);
        endcase
    end

endmodule

// ===== rtl/core/tfb_seq.sv =====
// ----------------------------------------------------------------------------
// tfb_seq
// Step counter with conditional jumps; holds on a wait for input or output.
// ----------------------------------------------------------------------------
module tfb_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  tfb_pkg::status_t  status,
    output tfb_pkg::ctl_t     ctl,
    output logic              step_fire
);

    tfb_pkg::step_t pc_reg;
    tfb_pkg::step_t pc_next;
    logic           taken;
    logic           emit;

    tfb_urom u_urom
    (
        .step (pc_reg),
        .ctl  (ctl)
    );

    // Step completes unless waiting for an item or for the output slot
    assign emit      = (ctl.src != tfb_pkg::SRC_NONE);
    assign step_fire = !((ctl.accept && !status.in_valid) || (emit && !status.out_free));

    // Jump condition
    always_comb
    begin
        unique case (ctl.jmp)
            tfb_pkg::JMP_NONE:     taken = 1'b0;
            tfb_pkg::JMP_ALWAYS:   taken = 1'b1;
            tfb_pkg::JMP_IF_RAW:   taken = !status.angle_mode;
            tfb_pkg::JMP_IF_ANGLE: taken = status.angle_mode;
            default:               taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        priority if (!step_fire)
            pc_next = pc_reg;
        else if (taken)
            pc_next = ctl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= tfb_pkg::STEP_ACCEPT;
        else
            pc_reg <= pc_next;
    end

`ifndef SYNTHESIS
    a_accept_to_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && status.in_valid) |=> (pc_reg == tfb_pkg::STEP_MODE))
        else $error("accepted item did not advance to mode branch");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= tfb_pkg::STEP_ACC)
        else $error("step counter left the program");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.last && step_fire) |=> (pc_reg == tfb_pkg::STEP_ACCEPT))
        else $error("frame end did not return to accept step");
`endif

endmodule

// ===== rtl/core/tfb_dp.sv =====
// ----------------------------------------------------------------------------
// tfb_dp
// Datapath: item capture, angle scaler, checksums, config and output register.
// ----------------------------------------------------------------------------
module tfb_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tfb_pkg::ctl_t                    ctl,
    input  logic                             step_fire,
    output logic                             angle_mode,
    output logic                             out_free,
    // config
    input  logic                             cfg_valid,
    input  logic [tfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data,
    // input item
    input  logic                             op,
    input  logic signed [15:0]               raw_value_0,
    input  logic signed [15:0]               raw_value_1,
    input  logic signed [15:0]               raw_value_2,
    input  logic signed [15:0]               raw_value_3,
    input  logic signed [15:0]               raw_value_4,
    input  logic signed [15:0]               raw_value_5,
    input  logic signed [23:0]               roll_angle,
    input  logic signed [23:0]               pitch_angle,
    input  logic signed [23:0]               yaw_angle,
    // result item
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [7:0]                       frame_byte,
    output logic                             last_byte
);

    logic [7:0]         dest_reg;
    logic [7:0]         id_reg;
    logic               mode_reg;
    logic [15:0]        word_reg [6];
    logic signed [23:0] angle_reg [3];
    logic signed [31:0] prod_reg;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic [7:0]         acc_reg;
    logic [7:0]         acc_next;
    logic               out_valid_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;

    logic               accept_fire;
    logic               emit_fire;
    logic signed [23:0] angle_sel;
    logic signed [31:0] biased;
    logic signed [23:0] quot;
    logic [15:0]        scaled;
    logic [15:0]        word_sel;
    logic [7:0]         byte_sel;

    assign accept_fire = ctl.accept && step_fire;
    assign emit_fire   = (ctl.src != tfb_pkg::SRC_NONE) && step_fire;
    assign angle_mode  = mode_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= tfb_pkg::DEST_RESET;
            id_reg   <= tfb_pkg::ID_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tfb_pkg::REG_DEST)
                dest_reg <= cfg_data;
            if (cfg_index == tfb_pkg::REG_ID)
                id_reg <= cfg_data;
        end
    end

    // Angle operand select
    always_comb
    begin
        unique case (ctl.mul_idx)
            2'd0:    angle_sel = angle_reg[0];
            2'd1:    angle_sel = angle_reg[1];
            default: angle_sel = angle_reg[2];
        endcase
    end

    // Divide by 256 truncating toward zero, then saturate to int16
    assign biased = prod_reg + {24'd0, {8{prod_reg[31]}}};
    assign quot   = biased[31:tfb_pkg::ANGLE_FRAC_BITS];

    always_comb
    begin
        priority if (quot > 24'sd32767)
            scaled = 16'h7FFF;
        else if (quot < -24'sd32768)
            scaled = 16'h8000;
        else
            scaled = quot[15:0];
    end

    // Item capture, multiplier stage and word store
    always_ff @(posedge clk)
    begin
        if (accept_fire)
        begin
            mode_reg     <= op;
            word_reg[0]  <= raw_value_0;
            word_reg[1]  <= raw_value_1;
            word_reg[2]  <= raw_value_2;
            word_reg[3]  <= raw_value_3;
            word_reg[4]  <= raw_value_4;
            word_reg[5]  <= raw_value_5;
            angle_reg[0] <= roll_angle;
            angle_reg[1] <= pitch_angle;
            angle_reg[2] <= yaw_angle;
        end
        else if (ctl.store_en && step_fire)
            word_reg[{1'b0, ctl.store_idx}] <= scaled;
        if (ctl.mul_en && step_fire)
            prod_reg <= angle_sel * tfb_pkg::ANGLE_SCALE;
    end

    // Byte select
    assign word_sel = word_reg[ctl.byte_idx[3:1]];

    always_comb
    begin
        unique case (ctl.src)
            tfb_pkg::SRC_SYNC: byte_sel = tfb_pkg::SYNC_BYTE;
            tfb_pkg::SRC_DEST: byte_sel = dest_reg;
            tfb_pkg::SRC_ID:   byte_sel = id_reg;
            tfb_pkg::SRC_LEN:  byte_sel = mode_reg ? tfb_pkg::LEN_ANGLE : tfb_pkg::LEN_RAW;
            tfb_pkg::SRC_WORD: byte_sel = ctl.byte_idx[0] ? word_sel[15:8] : word_sel[7:0];
            tfb_pkg::SRC_SUM:  byte_sel = sum_reg;
            tfb_pkg::SRC_ACC:  byte_sel = acc_reg;
            default:           byte_sel = 8'd0;
        endcase
    end

    // Running sum and sum of sums
    assign sum_next = sum_reg + byte_sel;
    assign acc_next = acc_reg + sum_next;

    always_ff @(posedge clk)
    begin
        if (accept_fire)
        begin
            sum_reg <= 8'd0;
            acc_reg <= 8'd0;
        end
        else if (emit_fire && ctl.ck_en)
        begin
            sum_reg <= sum_next;
            acc_reg <= acc_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            byte_reg <= byte_sel;
            last_reg <= ctl.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

`ifndef SYNTHESIS
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !emit_fire) |=> !out_valid_reg)
        else $error("output item still presented after it was taken");

    a_ck_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept_fire |=> (sum_reg == 8'd0 && acc_reg == 8'd0))
        else $error("checksums not cleared at item start");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(byte_reg)))
        else $error("stalled output byte overwritten");
`endif

endmodule

// ===== rtl/core/telemetry_frame_builder.sv =====
// The first frame byte is registered in the sync step, after the accept step and the
// mode branch (raw) or after these and the 4 multiply/store steps (angle). A new item
// is taken only once the previous frame is out (one byte per step of the microcode).
// Output stalls hold the step counter on the current emit step.
// Reset (rst_n, async, low): step counter to accept, output empty, destination 0xFF,
// frame id 0xF1.
// ----------------------------------------------------------------------------
// telemetry_frame_builder
// Builds one telemetry frame per item and emits it byte by byte with checksums.
// ----------------------------------------------------------------------------
module telemetry_frame_builder
(
    input  logic                          clk,
    input  logic                          rst_n,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    // input item channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic signed [15:0]            raw_value_0,
    input  logic signed [15:0]            raw_value_1,
    input  logic signed [15:0]            raw_value_2,
    input  logic signed [15:0]            raw_value_3,
    input  logic signed [15:0]            raw_value_4,
    input  logic signed [15:0]            raw_value_5,
    input  logic signed [23:0]            roll_angle,
    input  logic signed [23:0]            pitch_angle,
    input  logic signed [23:0]            yaw_angle,
    // result item channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    frame_byte,
    output logic                          last_byte
);

    tfb_pkg::ctl_t    ctl;
    tfb_pkg::status_t status;
    logic             step_fire;
    logic             angle_mode;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = !ctl.accept;

    assign status.in_valid   = in_valid;
    assign status.out_free   = out_free;
    assign status.angle_mode = angle_mode;

    tfb_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .ctl       (ctl),
        .step_fire (step_fire)
    );

    tfb_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .step_fire   (step_fire),
        .angle_mode  (angle_mode),
        .out_free    (out_free),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .raw_value_0 (raw_value_0),
        .raw_value_1 (raw_value_1),
        .raw_value_2 (raw_value_2),
        .raw_value_3 (raw_value_3),
        .raw_value_4 (raw_value_4),
        .raw_value_5 (raw_value_5),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte)
    );

endmodule

// ===== tb/frame_checker.sv =====
// ----------------------------------------------------------------------------
// frame_checker
// Watches the config, request and byte channels of the telemetry frame
// builder. Builds the expected frame for every accepted request from its own
// copy of the header registers and compares each emitted byte in order.
// ----------------------------------------------------------------------------
module frame_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          op,
    input  logic [15:0]                   raw_value_0,
    input  logic [15:0]                   raw_value_1,
    input  logic [15:0]                   raw_value_2,
    input  logic [15:0]                   raw_value_3,
    input  logic [15:0]                   raw_value_4,
    input  logic [15:0]                   raw_value_5,
    input  logic [23:0]                   roll_angle,
    input  logic [23:0]                   pitch_angle,
    input  logic [23:0]                   yaw_angle,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    frame_byte,
    input  logic                          last_byte,
    output int                            error_count,
    output int                            bytes_pending
);

    localparam longint DEG_TO_CENTI = 100;
    localparam int     PRINT_CAP    = 100;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } tx_byte_t;

    // Expected bytes in transmit order, oldest first
    tx_byte_t   expected_bytes[$];
    logic [7:0] dest_copy;
    logic [7:0] id_copy;

    initial error_count = 0;

    // One line per mismatch; printing stops after a cap, counting does not
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] frame check: %s", $time, msg);
        error_count++;
    endtask

    // Q15.8 degrees to centidegrees, truncated toward zero, saturated to int16
    function automatic logic [15:0] centi_word(input logic signed [23:0] angle);
        longint product;
        longint quotient;
        product = longint'(angle) * DEG_TO_CENTI;
        if (product < 0)
            quotient = -((-product) >>> tfb_pkg::ANGLE_FRAC_BITS);
        else
            quotient = product >>> tfb_pkg::ANGLE_FRAC_BITS;
        if (quotient > 32767)
            quotient = 32767;
        if (quotient < -32768)
            quotient = -32768;
        return quotient[15:0];
    endfunction

    // Build the whole frame for the request on the input ports
    task automatic queue_frame();
        logic [15:0] words[6];
        logic [7:0]  bytes[18];
        int          nwords;
        int          count;
        logic [7:0]  sum;
        logic [7:0]  acc;
        tx_byte_t    entry;
        sum = 8'd0;
        acc = 8'd0;
        bytes[0] = tfb_pkg::SYNC_BYTE;
        bytes[1] = dest_copy;
        bytes[2] = id_copy;
        if (!op)
        begin
            nwords   = 6;
            bytes[3] = tfb_pkg::LEN_RAW;
            words[0] = raw_value_0;
            words[1] = raw_value_1;
            words[2] = raw_value_2;
            words[3] = raw_value_3;
            words[4] = raw_value_4;
            words[5] = raw_value_5;
        end
        else
        begin
            nwords   = 3;
            bytes[3] = tfb_pkg::LEN_ANGLE;
            words[0] = centi_word(roll_angle);
            words[1] = centi_word(pitch_angle);
            words[2] = centi_word(yaw_angle);
        end
        count = 4;
        // little-endian payload
        for (int i = 0; i < nwords; i++)
        begin
            bytes[count]     = words[i][7:0];
            bytes[count + 1] = words[i][15:8];
            count            = count + 2;
        end
        // running sum and sum of running sums
        for (int i = 0; i < count; i++)
        begin
            sum = sum + bytes[i];
            acc = acc + sum;
        end
        bytes[count]     = sum;
        bytes[count + 1] = acc;
        count            = count + 2;
        for (int i = 0; i < count; i++)
        begin
            entry.value = bytes[i];
            entry.last  = (i == count - 1);
            expected_bytes.push_back(entry);
        end
    endtask

    // Compare one emitted byte with the oldest expectation
    task automatic check_byte();
        tx_byte_t want;
        if (expected_bytes.size() == 0)
            report_mismatch($sformatf("byte %02h with no frame pending", frame_byte));
        else
        begin
            want = expected_bytes.pop_front();
            if (frame_byte !== want.value)
                report_mismatch($sformatf("frame_byte got %02h want %02h",
                                          frame_byte, want.value));
            if (last_byte !== want.last)
                report_mismatch($sformatf("last_byte got %b want %b",
                                          last_byte, want.last));
        end
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_copy     <= tfb_pkg::DEST_RESET;
            id_copy       <= tfb_pkg::ID_RESET;
            bytes_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tfb_pkg::REG_DEST)
                    dest_copy <= cfg_data;
                else if (cfg_index == tfb_pkg::REG_ID)
                    id_copy <= cfg_data;
            end
            if (in_valid && !in_stall)
                queue_frame();
            if (out_valid && !out_stall)
                check_byte();
            bytes_pending <= expected_bytes.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the telemetry frame builder with directed edge cases and random raw
// and angle requests over several header settings and idle/stall mixes.
// The frame checker does the prediction and comparison; this module makes
// the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

    // Indexes past the register file; writes there must be ignored
    localparam logic [tfb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [tfb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int PHASE_ITEMS = 60;
    localparam int DRAIN_WAIT  = 40;

    // Angle codes around the int16 saturation point (x100/256)
    localparam int ANG_MAX_POS   = 83886;   // exactly 32767
    localparam int ANG_OVER_POS  = 83887;   // saturates high
    localparam int ANG_EDGE_NEG  = -83887;  // exactly -32768
    localparam int ANG_OVER_NEG  = -83890;  // saturates low
    localparam int ANG_FULL_TURN = 92160;   // 360 degrees

    typedef struct packed {
        logic            op;
        logic [5:0][15:0] raw;
        logic [2:0][23:0] angle;
    } frame_req_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tfb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          op;
    logic [15:0]                   raw_value_0;
    logic [15:0]                   raw_value_1;
    logic [15:0]                   raw_value_2;
    logic [15:0]                   raw_value_3;
    logic [15:0]                   raw_value_4;
    logic [15:0]                   raw_value_5;
    logic [23:0]                   roll_angle;
    logic [23:0]                   pitch_angle;
    logic [23:0]                   yaw_angle;
    logic                          out_valid;
    logic                          out_stall;
    logic [7:0]                    frame_byte;
    logic                          last_byte;

    int error_count;
    int bytes_pending;
    int gap_pct;
    int stall_pct;

    telemetry_frame_builder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .raw_value_0 (raw_value_0),
        .raw_value_1 (raw_value_1),
        .raw_value_2 (raw_value_2),
        .raw_value_3 (raw_value_3),
        .raw_value_4 (raw_value_4),
        .raw_value_5 (raw_value_5),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte)
    );

    frame_checker frame_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .raw_value_0   (raw_value_0),
        .raw_value_1   (raw_value_1),
        .raw_value_2   (raw_value_2),
        .raw_value_3   (raw_value_3),
        .raw_value_4   (raw_value_4),
        .raw_value_5   (raw_value_5),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle),
        .yaw_angle     (yaw_angle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte),
        .error_count   (error_count),
        .bytes_pending (bytes_pending)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog
    initial
    begin
        #800000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Byte-side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Raw request; the angle fields are don't-care and get noise
    function automatic frame_req_t raw_frame(input logic [15:0] v0, v1, v2, v3, v4, v5);
        frame_req_t req;
        req.op  = 1'b0;
        req.raw = {v5, v4, v3, v2, v1, v0};
        for (int i = 0; i < 3; i++)
            req.angle[i] = 24'($urandom);
        return req;
    endfunction

    // Angle request; the raw fields are don't-care and get noise
    function automatic frame_req_t angle_frame(input int roll, pitch, yaw);
        frame_req_t req;
        req.op       = 1'b1;
        req.angle[0] = roll[23:0];
        req.angle[1] = pitch[23:0];
        req.angle[2] = yaw[23:0];
        for (int i = 0; i < 6; i++)
            req.raw[i] = 16'($urandom);
        return req;
    endfunction

    // Random request; angles mix full range, realistic, tiny and near saturation
    function automatic frame_req_t random_frame();
        frame_req_t req;
        int         val;
        req.op = 1'($urandom_range(1));
        for (int i = 0; i < 6; i++)
            req.raw[i] = 16'($urandom);
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(3))
                0: val = $urandom;
                1: val = int'($urandom_range(2 * ANG_FULL_TURN)) - ANG_FULL_TURN;
                2: val = int'($urandom_range(1200)) - 600;
                default:
                begin
                    val = int'($urandom_range(ANG_OVER_NEG - ANG_EDGE_NEG + 10))
                          + ANG_MAX_POS - 5;
                    if ($urandom_range(1))
                        val = -val;
                end
            endcase
            req.angle[i] = val[23:0];
        end
        return req;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_item(input frame_req_t req);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= req.op;
        raw_value_0 <= req.raw[0];
        raw_value_1 <= req.raw[1];
        raw_value_2 <= req.raw[2];
        raw_value_3 <= req.raw[3];
        raw_value_4 <= req.raw[4];
        raw_value_5 <= req.raw[5];
        roll_angle  <= req.angle[0];
        pitch_angle <= req.angle[1];
        yaw_angle   <= req.angle[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending until every expected byte has come out
    task automatic wait_frames_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
    endtask

    // Config write; the caller drops cfg_valid after its last write
    task automatic write_reg(input logic [tfb_pkg::CFG_IDX_W-1:0] index,
                             input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Header setting plus a write to an unused index, then a random phase
    task automatic run_phase(input int gap, input int stall,
                             input logic [7:0] dest, input logic [7:0] id,
                             input logic [tfb_pkg::CFG_IDX_W-1:0] spare);
        wait_frames_done();
        write_reg(tfb_pkg::REG_DEST, dest);
        write_reg(spare, 8'($urandom));
        write_reg(tfb_pkg::REG_ID, id);
        cfg_valid <= 1'b0;
        gap_pct   = gap;
        stall_pct = stall;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(39) == 0)
                wait_frames_done();
            send_item(random_frame());
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        gap_pct     = 0;
        stall_pct   = 0;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= tfb_pkg::REG_DEST;
        cfg_data    <= 8'h00;
        in_valid    <= 1'b0;
        op          <= 1'b0;
        raw_value_0 <= 16'h0000;
        raw_value_1 <= 16'h0000;
        raw_value_2 <= 16'h0000;
        raw_value_3 <= 16'h0000;
        raw_value_4 <= 16'h0000;
        raw_value_5 <= 16'h0000;
        roll_angle  <= 24'h000000;
        pitch_angle <= 24'h000000;
        yaw_angle   <= 24'h000000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset header values
        send_item(raw_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(raw_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_item(raw_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(raw_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(raw_frame(16'h0001, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h8001));
        send_item(angle_frame(0, 0, 0));
        send_item(angle_frame(8388607, -8388608, ANG_FULL_TURN));
        send_item(angle_frame(ANG_MAX_POS, ANG_OVER_POS, -ANG_MAX_POS));
        send_item(angle_frame(ANG_EDGE_NEG, ANG_OVER_NEG, -ANG_FULL_TURN));
        // truncation toward zero on small negatives
        send_item(angle_frame(-1, -3, -255));
        send_item(angle_frame(1, 3, 256));
        send_item(angle_frame(-256, -257, 255));
        send_item(angle_frame(8388607, 8388607, 8388607));
        send_item(angle_frame(-8388608, -8388608, -8388608));

        run_phase(0, 0, 8'h00, 8'h00, REG_SPARE_LO);
        run_phase(59, 0, 8'hFF, 8'hFF, REG_SPARE_HI);
        run_phase(0, 59, 8'($urandom), 8'($urandom), REG_SPARE_LO);
        run_phase(20, 20, 8'($urandom), 8'($urandom), REG_SPARE_HI);

        wait_frames_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && bytes_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
